FILE: sv/exhaust_flame_flicker_fsm_macros.svh
// ----------------------------------------------------------------------------
// exhaust flame flicker assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef EXHAUST_FLAME_FLICKER_FSM_MACROS_SVH
`define EXHAUST_FLAME_FLICKER_FSM_MACROS_SVH

// same-cycle implication
`define EFF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EFF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/eff_pkg.sv
// ----------------------------------------------------------------------------
// eff_pkg
// types and constants shared by the exhaust flame flicker block
// ----------------------------------------------------------------------------
`default_nettype none

package eff_pkg;

  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 39;
  localparam int unsigned RAND_BITS      = 16;
  localparam int unsigned PERCENT_BITS   = 7;
  localparam int unsigned FIELD_BITS     = 8;
  localparam int unsigned DRAW_BITS      = FIELD_BITS + 1;
  localparam int unsigned PRODUCT_BITS   = RAND_BITS + FIELD_BITS;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_POP_LEVEL      = 3'd0;
  localparam cfg_index_t REG_BRIGHT_LEVEL   = 3'd1;
  localparam cfg_index_t REG_DIM_LEVEL      = 3'd2;
  localparam cfg_index_t REG_MAX_INTENSITY  = 3'd3;
  localparam cfg_index_t REG_DIM_PROFILE    = 3'd4;
  localparam cfg_index_t REG_BRIGHT_PROFILE = 3'd5;
  localparam cfg_index_t REG_POP_PROFILE    = 3'd6;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_DIM    = 2'd1,
    KIND_BRIGHT = 2'd2,
    KIND_POP    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [PERCENT_BITS-1:0] chance;
    logic [FIELD_BITS-1:0]   chg_span;
    logic [FIELD_BITS-1:0]   chg_min;
    logic [FIELD_BITS-1:0]   start_span;
    logic [FIELD_BITS-1:0]   start_min;
  } profile_t;

  typedef struct packed {
    logic  rising;
    logic  quench;
    logic  start;
    logic  drift;
    kind_t start_kind;
  } frame_dec_t;

endpackage

`default_nettype wire

FILE: sv/eff_if.sv
// ----------------------------------------------------------------------------
// eff_if
// valid/ready channels for frame beats and flame result beats
// ----------------------------------------------------------------------------
`default_nettype none

interface eff_in_if #(
  parameter int THROTTLE_BITS = 10
) ();
  import eff_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [THROTTLE_BITS-1:0] throttle;
  logic [RAND_BITS-1:0]     rand_word;
  logic [PERCENT_BITS-1:0]  rand_percent;

  modport source (output valid, throttle, rand_word, rand_percent, input ready);
  modport sink   (input valid, throttle, rand_word, rand_percent, output ready);
endinterface

interface eff_out_if #(
  parameter int LEVEL_BITS = 8
) ();
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] intensity;
  logic [1:0]            flame_kind;

  modport source (output valid, intensity, flame_kind, input ready);
  modport sink   (input valid, intensity, flame_kind, output ready);
endinterface

`default_nettype wire

FILE: sv/eff_cfg.sv
// ----------------------------------------------------------------------------
// eff_cfg
// configuration register file: thresholds, clamp and the three flame profiles
// ----------------------------------------------------------------------------
`default_nettype none

module eff_cfg #(
  parameter int THROTTLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  eff_pkg::cfg_index_t                 cfg_index,
  input  logic [eff_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic [THROTTLE_BITS-1:0]            pop_level,
  output logic [THROTTLE_BITS-1:0]            bright_level,
  output logic [THROTTLE_BITS-1:0]            dim_level,
  output logic [eff_pkg::FIELD_BITS-1:0]      max_intensity,
  output eff_pkg::profile_t                   dim_profile,
  output eff_pkg::profile_t                   bright_profile,
  output eff_pkg::profile_t                   pop_profile
);
  import eff_pkg::*;

  localparam logic [THROTTLE_BITS-1:0] POP_RESET    = THROTTLE_BITS'(900);
  localparam logic [THROTTLE_BITS-1:0] BRIGHT_RESET = THROTTLE_BITS'(700);
  localparam logic [THROTTLE_BITS-1:0] DIM_RESET    = THROTTLE_BITS'(600);

  always_ff @(posedge clk) begin
    if (rst) begin
      pop_level      <= POP_RESET;
      bright_level   <= BRIGHT_RESET;
      dim_level      <= DIM_RESET;
      max_intensity  <= '1;
      dim_profile    <= '0;
      bright_profile <= '0;
      pop_profile    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_POP_LEVEL:      pop_level      <= cfg_data[THROTTLE_BITS-1:0];
        REG_BRIGHT_LEVEL:   bright_level   <= cfg_data[THROTTLE_BITS-1:0];
        REG_DIM_LEVEL:      dim_level      <= cfg_data[THROTTLE_BITS-1:0];
        REG_MAX_INTENSITY:  max_intensity  <= cfg_data[FIELD_BITS-1:0];
        REG_DIM_PROFILE:    dim_profile    <= profile_t'(cfg_data);
        REG_BRIGHT_PROFILE: bright_profile <= profile_t'(cfg_data);
        REG_POP_PROFILE:    pop_profile    <= profile_t'(cfg_data);
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/eff_frame.sv
// ----------------------------------------------------------------------------
// eff_frame
// next-state logic for one frame: flame decision, random draw, start and drift
// ----------------------------------------------------------------------------
`default_nettype none

module eff_frame #(
  parameter int THROTTLE_BITS = 10,
  parameter int LEVEL_BITS    = 8
) (
  input  logic [THROTTLE_BITS-1:0]           throttle,
  input  logic [eff_pkg::RAND_BITS-1:0]      rand_word,
  input  logic [eff_pkg::PERCENT_BITS-1:0]   rand_percent,
  input  eff_pkg::kind_t                     kind_now,
  input  eff_pkg::kind_t                     kind_before,
  input  logic [LEVEL_BITS-1:0]              flame_level,
  input  logic [THROTTLE_BITS-1:0]           prior_throttle,
  input  logic [THROTTLE_BITS-1:0]           pop_level,
  input  logic [THROTTLE_BITS-1:0]           bright_level,
  input  logic [THROTTLE_BITS-1:0]           dim_level,
  input  logic [eff_pkg::FIELD_BITS-1:0]     max_intensity,
  input  eff_pkg::profile_t                  dim_profile,
  input  eff_pkg::profile_t                  bright_profile,
  input  eff_pkg::profile_t                  pop_profile,
  output eff_pkg::frame_dec_t                dec,
  output eff_pkg::kind_t                     kind_now_next,
  output eff_pkg::kind_t                     kind_before_next,
  output logic [LEVEL_BITS-1:0]              flame_level_next
);
  import eff_pkg::*;

  localparam int CW = ((LEVEL_BITS > DRAW_BITS) ? LEVEL_BITS : DRAW_BITS) + 2;
  localparam logic [CW-1:0] LEVEL_MAX = CW'((1 << LEVEL_BITS) - 1);

  logic                    level_zero;
  kind_t                   sel_kind;
  profile_t                prof;
  logic [FIELD_BITS-1:0]   draw_min;
  logic [FIELD_BITS-1:0]   draw_span;
  logic [PRODUCT_BITS-1:0] product;
  logic [DRAW_BITS-1:0]    draw;
  logic [CW-1:0]           draw_w;
  logic [CW-1:0]           start_w;
  logic signed [CW-1:0]    level_s;
  logic signed [CW-1:0]    max_s;
  logic signed [CW-1:0]    rise_s;
  logic signed [CW-1:0]    fall_s;
  logic signed [CW-1:0]    nv;
  logic signed [CW-1:0]    clamped;

  assign level_zero = (flame_level == '0);

  always_comb begin
    dec            = '0;
    dec.start_kind = KIND_NONE;
    dec.rising     = (throttle > prior_throttle);
    if (dec.rising) begin
      dec.quench = 1'b1;
    end else if (kind_before == KIND_POP && level_zero) begin
      dec.start      = 1'b1;
      dec.start_kind = (throttle >= pop_level) ? KIND_POP : KIND_BRIGHT;
    end else if (kind_now != KIND_NONE) begin
      if (level_zero) begin
        dec.quench = 1'b1;
      end else begin
        dec.drift = 1'b1;
      end
    end else if (throttle >= pop_level) begin
      dec.start      = 1'b1;
      dec.start_kind = KIND_POP;
    end else if (prior_throttle >= bright_level && throttle != prior_throttle) begin
      dec.start      = 1'b1;
      dec.start_kind = KIND_BRIGHT;
    end else if (prior_throttle >= dim_level && throttle != prior_throttle) begin
      dec.start      = 1'b1;
      dec.start_kind = KIND_DIM;
    end
  end

  // one shared draw: start fields when a flame starts, change fields otherwise
  assign sel_kind = dec.start ? dec.start_kind : kind_now;

  always_comb begin
    case (sel_kind)
      KIND_DIM:    prof = dim_profile;
      KIND_BRIGHT: prof = bright_profile;
      KIND_POP:    prof = pop_profile;
      default:     prof = '0;
    endcase
  end

  assign draw_min  = dec.start ? prof.start_min  : prof.chg_min;
  assign draw_span = dec.start ? prof.start_span : prof.chg_span;
  assign product   = rand_word * draw_span;
  assign draw      = {1'b0, draw_min} + {1'b0, product[PRODUCT_BITS-1 -: FIELD_BITS]};

  assign draw_w  = CW'(draw);
  assign start_w = (draw_w > LEVEL_MAX) ? LEVEL_MAX : draw_w;

  assign level_s = CW'(flame_level);
  assign max_s   = CW'(max_intensity);
  assign rise_s  = level_s + CW'(draw >> 1);
  assign fall_s  = level_s - draw_w;
  assign nv      = (rand_percent <= prof.chance) ? rise_s : fall_s;

  always_comb begin
    if (nv > max_s) begin
      clamped = max_s;
    end else if (nv[CW-1]) begin
      clamped = '0;
    end else begin
      clamped = nv;
    end
  end

  always_comb begin
    kind_now_next    = kind_now;
    kind_before_next = kind_before;
    flame_level_next = flame_level;
    if (dec.quench) begin
      kind_before_next = kind_now;
      kind_now_next    = KIND_NONE;
    end else if (dec.start) begin
      kind_before_next = kind_now;
      kind_now_next    = dec.start_kind;
      flame_level_next = start_w[LEVEL_BITS-1:0];
    end else if (dec.drift) begin
      flame_level_next = clamped[LEVEL_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: sv/exhaust_flame_flicker_fsm.sv
// ----------------------------------------------------------------------------
// exhaust_flame_flicker_fsm
// exhaust flame flicker state machine, one animation frame per beat
//
//   channel    dir   beat contents
//   frame_in   in    throttle, rand_word, rand_percent
//   frame_out  out   intensity, flame_kind
//   cfg        in    cfg_wr_en, cfg_index, cfg_data (write only)
//
// one frame per cycle sustained while frame_out is ready; a beat is held in
// the input register, then its result in the result register; the flame state
// loop closes through combinational frame logic and its single 16x8 multiply
// a stalled result holds in the output register while the input register
// keeps accepting until it too is full
// rst is synchronous and restores the register reset values and no flame
// ----------------------------------------------------------------------------
`default_nettype none
`include "exhaust_flame_flicker_fsm_macros.svh"

module exhaust_flame_flicker_fsm #(
  parameter int THROTTLE_BITS = 10,
  parameter int LEVEL_BITS    = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  eff_in_if.sink                            frame_in,
  eff_out_if.source                         frame_out,
  input  logic                              cfg_wr_en,
  input  eff_pkg::cfg_index_t               cfg_index,
  input  logic [eff_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import eff_pkg::*;

  logic [THROTTLE_BITS-1:0] pop_level;
  logic [THROTTLE_BITS-1:0] bright_level;
  logic [THROTTLE_BITS-1:0] dim_level;
  logic [FIELD_BITS-1:0]    max_intensity;
  profile_t                 dim_profile;
  profile_t                 bright_profile;
  profile_t                 pop_profile;

  logic                     in_valid;
  logic [THROTTLE_BITS-1:0] thr_q;
  logic [RAND_BITS-1:0]     rnd_q;
  logic [PERCENT_BITS-1:0]  pct_q;

  kind_t                    kind_now;
  kind_t                    kind_before;
  logic [LEVEL_BITS-1:0]    flame_level;
  logic [THROTTLE_BITS-1:0] prior_throttle;

  kind_t                    kind_now_next;
  kind_t                    kind_before_next;
  logic [LEVEL_BITS-1:0]    flame_level_next;
  frame_dec_t               dec;

  logic                     out_valid;
  logic [LEVEL_BITS-1:0]    out_intensity;
  kind_t                    out_kind;
  logic                     advance;

  eff_cfg #(
    .THROTTLE_BITS (THROTTLE_BITS)
  ) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pop_level      (pop_level),
    .bright_level   (bright_level),
    .dim_level      (dim_level),
    .max_intensity  (max_intensity),
    .dim_profile    (dim_profile),
    .bright_profile (bright_profile),
    .pop_profile    (pop_profile)
  );

  eff_frame #(
    .THROTTLE_BITS (THROTTLE_BITS),
    .LEVEL_BITS    (LEVEL_BITS)
  ) u_frame (
    .throttle         (thr_q),
    .rand_word        (rnd_q),
    .rand_percent     (pct_q),
    .kind_now         (kind_now),
    .kind_before      (kind_before),
    .flame_level      (flame_level),
    .prior_throttle   (prior_throttle),
    .pop_level        (pop_level),
    .bright_level     (bright_level),
    .dim_level        (dim_level),
    .max_intensity    (max_intensity),
    .dim_profile      (dim_profile),
    .bright_profile   (bright_profile),
    .pop_profile      (pop_profile),
    .dec              (dec),
    .kind_now_next    (kind_now_next),
    .kind_before_next (kind_before_next),
    .flame_level_next (flame_level_next)
  );

  assign advance        = in_valid && (!out_valid || frame_out.ready);
  assign frame_in.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (frame_in.ready) begin
      in_valid <= frame_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_in.ready && frame_in.valid) begin
      thr_q <= frame_in.throttle;
      rnd_q <= frame_in.rand_word;
      pct_q <= frame_in.rand_percent;
    end
  end

  // flame state
  always_ff @(posedge clk) begin
    if (rst) begin
      kind_now       <= KIND_NONE;
      kind_before    <= KIND_NONE;
      flame_level    <= '0;
      prior_throttle <= '0;
    end else if (advance) begin
      kind_now       <= kind_now_next;
      kind_before    <= kind_before_next;
      flame_level    <= flame_level_next;
      prior_throttle <= thr_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (frame_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_intensity <= flame_level_next;
      out_kind      <= kind_now_next;
    end
  end

  assign frame_out.valid      = out_valid;
  assign frame_out.intensity  = out_intensity;
  assign frame_out.flame_kind = out_kind;

  `EFF_ASSERT_NOW(a_out_matches_state, out_valid, (out_intensity == flame_level) && (out_kind == kind_now), "result beat differs from flame state")
  `EFF_ASSERT_NEXT(a_state_holds, !advance, $stable(flame_level) && $stable(kind_now) && $stable(prior_throttle), "flame state changed without a frame")
  `EFF_ASSERT_NEXT(a_rise_quenches, advance && dec.rising, kind_now == KIND_NONE, "rising throttle left a flame lit")
  `EFF_ASSERT_NOW(a_ready_when_empty, !out_valid, frame_in.ready, "input stalled with an empty result register")

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the exhaust flame flicker state machine: frames go
// in on a valid/ready channel in random bursts, results are stalled on a
// changing pattern, and each result beat is compared with a frame-by-frame
// prediction of flame kind and intensity across several register settings
// ----------------------------------------------------------------------------

module tb;
  import eff_pkg::*;

  localparam int THR_BITS         = 10;
  localparam int LVL_BITS         = 8;
  localparam int LEVEL_TOP        = (1 << LVL_BITS) - 1;
  localparam int IDLE_LIMIT       = 2000;
  localparam int SETTLE_CYCLES    = 6;
  localparam int PHASES           = 10;
  localparam int FRAMES_PER_PHASE = 123;
  localparam int REPORT_LIMIT     = 10;

  typedef struct {
    logic [LVL_BITS-1:0] intensity;
    kind_t               kind;
  } flame_out_t;

  typedef enum {RX_OPEN, RX_PERIODIC, RX_BURSTY, RX_COIN} rx_mode_t;

  class flame_scoreboard;
    kind_t               kind_now;
    kind_t               kind_before;
    logic [LVL_BITS-1:0] level;
    logic [LVL_BITS-1:0] max_level;
    logic [THR_BITS-1:0] prior_thr;
    logic [THR_BITS-1:0] pop_lvl;
    logic [THR_BITS-1:0] bright_lvl;
    logic [THR_BITS-1:0] dim_lvl;
    profile_t            prof [4];
    flame_out_t          expected_q [$];
    int unsigned         frames;
    int unsigned         results;
    int unsigned         mismatches;
    int unsigned         kind_hits [4];

    function new();
      kind_now    = KIND_NONE;
      kind_before = KIND_NONE;
      level       = '0;
      prior_thr   = '0;
      pop_lvl     = THR_BITS'(900);
      bright_lvl  = THR_BITS'(700);
      dim_lvl     = THR_BITS'(600);
      max_level   = LVL_BITS'(255);
      foreach (prof[k]) prof[k] = '0;
      foreach (kind_hits[k]) kind_hits[k] = 0;
      frames     = 0;
      results    = 0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_POP_LEVEL:      pop_lvl = data[THR_BITS-1:0];
        REG_BRIGHT_LEVEL:   bright_lvl = data[THR_BITS-1:0];
        REG_DIM_LEVEL:      dim_lvl = data[THR_BITS-1:0];
        REG_MAX_INTENSITY:  max_level = data[LVL_BITS-1:0];
        REG_DIM_PROFILE:    prof[KIND_DIM] = data;
        REG_BRIGHT_PROFILE: prof[KIND_BRIGHT] = data;
        REG_POP_PROFILE:    prof[KIND_POP] = data;
        default: ;
      endcase
    endfunction

    function int unsigned scaled_draw(logic [7:0] lo, logic [7:0] span, logic [15:0] rnd);
      int unsigned prod;
      prod = 32'(rnd) * 32'(span);
      return 32'(lo) + (prod >> 16);
    endfunction

    function void ignite(kind_t k, logic [15:0] rnd);
      int unsigned v;
      v = scaled_draw(prof[k].start_min, prof[k].start_span, rnd);
      kind_before = kind_now;
      kind_now    = k;
      level       = (v > LEVEL_TOP) ? '1 : v[LVL_BITS-1:0];
    endfunction

    function void flicker(logic [15:0] rnd, logic [6:0] pct);
      profile_t p;
      int       change;
      int       nv;
      p      = prof[kind_now];
      change = int'(scaled_draw(p.chg_min, p.chg_span, rnd));
      if (pct <= p.chance) nv = int'(level) + change / 2;
      else nv = int'(level) - change;
      if (nv > int'(max_level)) nv = int'(max_level);
      else if (nv < 0) nv = 0;
      level = nv[LVL_BITS-1:0];
    endfunction

    function void note_frame(logic [THR_BITS-1:0] thr, logic [15:0] rnd, logic [6:0] pct);
      if (thr > prior_thr) begin
        kind_before = kind_now;
        kind_now    = KIND_NONE;
      end else if (kind_before == KIND_POP && level == 0) begin
        if (thr >= pop_lvl) ignite(KIND_POP, rnd);
        else ignite(KIND_BRIGHT, rnd);
      end else if (kind_now != KIND_NONE) begin
        if (level == 0) begin
          kind_before = kind_now;
          kind_now    = KIND_NONE;
        end else begin
          flicker(rnd, pct);
        end
      end else if (thr >= pop_lvl) begin
        ignite(KIND_POP, rnd);
      end else if (prior_thr >= bright_lvl && thr < prior_thr) begin
        ignite(KIND_BRIGHT, rnd);
      end else if (prior_thr >= dim_lvl && thr < prior_thr) begin
        ignite(KIND_DIM, rnd);
      end
      prior_thr = thr;
      frames++;
      expected_q.push_back('{intensity: level, kind: kind_now});
    endfunction

    function void check_result(logic [LVL_BITS-1:0] intensity, logic [1:0] kind);
      flame_out_t exp_beat;
      results++;
      kind_hits[kind]++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result beat %0d with nothing expected: intensity %0d kind %0d",
                   results, intensity, kind);
        return;
      end
      exp_beat = expected_q.pop_front();
      if (intensity !== exp_beat.intensity || kind !== exp_beat.kind) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result beat %0d: expected intensity %0d kind %0d, got intensity %0d kind %0d",
                   results, exp_beat.intensity, exp_beat.kind, intensity, kind);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     cfg_wr_en;
  cfg_index_t               cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic [THR_BITS-1:0]      last_thr;
  int unsigned              cfg_writes;

  eff_in_if  #(.THROTTLE_BITS(THR_BITS)) frame_in ();
  eff_out_if #(.LEVEL_BITS(LVL_BITS))    frame_out ();

  flame_scoreboard sb = new();

  exhaust_flame_flicker_fsm #(
    .THROTTLE_BITS(THR_BITS),
    .LEVEL_BITS   (LVL_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .frame_in (frame_in),
    .frame_out(frame_out),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic program_all(logic [THR_BITS-1:0] pop, bright, dim, logic [7:0] maxi,
                             profile_t dp, bp, pp);
    write_reg(REG_POP_LEVEL, CFG_DATA_BITS'(pop));
    write_reg(REG_BRIGHT_LEVEL, CFG_DATA_BITS'(bright));
    write_reg(REG_DIM_LEVEL, CFG_DATA_BITS'(dim));
    write_reg(REG_MAX_INTENSITY, CFG_DATA_BITS'(maxi));
    write_reg(REG_DIM_PROFILE, dp);
    write_reg(REG_BRIGHT_PROFILE, bp);
    write_reg(REG_POP_PROFILE, pp);
  endtask

  task automatic send_frame(logic [THR_BITS-1:0] thr, logic [15:0] rnd, logic [6:0] pct);
    @(negedge clk);
    frame_in.valid        <= 1'b1;
    frame_in.throttle     <= thr;
    frame_in.rand_word    <= rnd;
    frame_in.rand_percent <= pct;
    last_thr = thr;
    @(posedge clk);
    while (!frame_in.ready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    frame_in.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic profile_t rand_profile();
    profile_t p;
    p.start_min  = 8'($urandom_range(20, 200));
    p.start_span = 8'($urandom);
    p.chg_min    = 8'($urandom_range(0, 24));
    p.chg_span   = 8'($urandom_range(0, 80));
    case ($urandom_range(0, 5))
      0: p.chance = '0;
      1: p.chance = '1;
      default: p.chance = 7'($urandom_range(10, 90));
    endcase
    return p;
  endfunction

  // throttle mostly holds or eases off so flames get to live and drift
  task automatic run_frames(int count, int pause_at);
    int                  burst;
    int                  gap;
    int                  pick;
    int                  drop;
    logic [THR_BITS-1:0] thr;
    logic [15:0]         rnd;
    logic [6:0]          pct;
    burst = $urandom_range(1, 60);
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) wait_for_results();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        thr = last_thr;
      end else if (pick < 70) begin
        drop = $urandom_range(0, 80);
        thr  = (int'(last_thr) > drop) ? THR_BITS'(int'(last_thr) - drop) : '0;
      end else if (pick < 85) begin
        thr = THR_BITS'($urandom_range(500, 1023));
      end else begin
        thr = THR_BITS'($urandom_range(0, 1023));
      end
      case ($urandom_range(0, 9))
        0: rnd = '0;
        1: rnd = '1;
        default: rnd = 16'($urandom);
      endcase
      pct = 7'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 99));
      send_frame(thr, rnd, pct);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 60);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          @(negedge clk);
          frame_in.valid <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  endtask

  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       stall_left;
    int       tick;
    frame_out.ready = 1'b0;
    mode       = RX_OPEN;
    mode_left  = 0;
    stall_left = 0;
    tick       = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(40, 200);
      end
      mode_left--;
      tick++;
      if (stall_left > 0) begin
        stall_left--;
        frame_out.ready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:     frame_out.ready <= 1'b1;
          RX_PERIODIC: frame_out.ready <= (tick % 3 != 0);
          RX_BURSTY: begin
            if ($urandom_range(0, 4) == 0) begin
              stall_left = $urandom_range(0, 5);
              frame_out.ready <= 1'b0;
            end else begin
              frame_out.ready <= 1'b1;
            end
          end
          default: frame_out.ready <= ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  // beat monitor and watchdog on cycles with no beat moving
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (frame_in.valid && frame_in.ready) begin
          sb.note_frame(frame_in.throttle, frame_in.rand_word, frame_in.rand_percent);
          idle_cycles = 0;
        end
        if (frame_out.valid && frame_out.ready) begin
          sb.check_result(frame_out.intensity, frame_out.flame_kind);
          idle_cycles = 0;
        end
      end
    end
    $display("exhaust_flame_flicker_fsm verification failed");
    $finish;
  end

  initial begin
    logic [THR_BITS-1:0] pop;
    logic [THR_BITS-1:0] bright;
    logic [THR_BITS-1:0] dim;
    logic [7:0]          maxi;
    rst                   = 1'b1;
    cfg_wr_en             = 1'b0;
    cfg_index             = REG_POP_LEVEL;
    cfg_data              = '0;
    frame_in.valid        = 1'b0;
    frame_in.throttle     = '0;
    frame_in.rand_word    = '0;
    frame_in.rand_percent = '0;
    last_thr              = '0;
    cfg_writes            = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset registers: zero start draws, pop retrigger keeps coming back
    send_frame(10'd1023, 16'h0000, 7'd0);
    send_frame(10'd1023, 16'h0000, 7'd0);
    send_frame(10'd1023, 16'hffff, 7'd0);
    send_frame(10'd1023, 16'h0000, 7'd0);
    send_frame(10'd1023, 16'h0000, 7'd0);
    send_frame(10'd500, 16'hffff, 7'd99);
    wait_for_results();

    program_all(10'd900, 10'd700, 10'd600, 8'd255,
                profile_t'{7'd127, 8'd40, 8'd10, 8'd100, 8'd100},
                profile_t'{7'd0, 8'd20, 8'd5, 8'd80, 8'd150},
                profile_t'{7'd50, 8'd255, 8'd0, 8'd255, 8'd200});
    send_frame(10'd0, 16'h0000, 7'd0);
    send_frame(10'd300, 16'h1234, 7'd50);
    send_frame(10'd300, 16'hffff, 7'd0);
    send_frame(10'd750, 16'h0000, 7'd0);
    send_frame(10'd650, 16'hffff, 7'd0);
    send_frame(10'd650, 16'h8000, 7'd99);
    send_frame(10'd650, 16'hffff, 7'd100);
    send_frame(10'd650, 16'h4000, 7'd127);
    send_frame(10'd680, 16'h0000, 7'd0);
    send_frame(10'd610, 16'hffff, 7'd0);
    send_frame(10'd610, 16'hffff, 7'd127);
    send_frame(10'd1023, 16'hffff, 7'd0);
    send_frame(10'd1023, 16'hffff, 7'd99);
    send_frame(10'd1023, 16'h0000, 7'd0);
    send_frame(10'd900, 16'h7fff, 7'd64);
    wait_for_results();

    for (int p = 1; p <= PHASES; p++) begin
      case (p)
        1: program_all('0, '0, '0, 8'd255, rand_profile(), rand_profile(), rand_profile());
        2: program_all('1, '1, '1, '1, '1, '1, '1);
        3: program_all(10'd900, 10'd700, 10'd600, 8'd0,
                       rand_profile(), rand_profile(), rand_profile());
        4: program_all(10'd850, 10'd650, 10'd500, 8'd200, '0, '0, '0);
        default: begin
          pop    = THR_BITS'($urandom_range(600, 1023));
          bright = THR_BITS'($urandom_range(300, pop));
          dim    = THR_BITS'($urandom_range(100, bright));
          maxi   = 8'($urandom_range(80, 255));
          program_all(pop, bright, dim, maxi, rand_profile(), rand_profile(), rand_profile());
        end
      endcase
      run_frames(FRAMES_PER_PHASE, (p == 5) ? FRAMES_PER_PHASE / 2 : -1);
      wait_for_results();
    end

    $display("%0d frames, %0d results over %0d register settings (%0d writes), %0d mismatches",
             sb.frames, sb.results, PHASES + 2, cfg_writes, sb.mismatches);
    $display("result kinds: none %0d, dim %0d, bright %0d, pop %0d",
             sb.kind_hits[KIND_NONE], sb.kind_hits[KIND_DIM],
             sb.kind_hits[KIND_BRIGHT], sb.kind_hits[KIND_POP]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("exhaust_flame_flicker_fsm verification clean");
    end else begin
      $display("exhaust_flame_flicker_fsm verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/eff_pkg.sv
sv/eff_if.sv
sv/eff_cfg.sv
sv/eff_frame.sv
sv/exhaust_flame_flicker_fsm.sv
dv/tb.sv
